[hw/rtl/ytm_pkg.sv]
package ytm_pkg;

    // Widths fixed by the sample format and the register map.
    localparam int SAMPLE_W    = 8;
    localparam int KEY_W       = 24;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Number of key slots that have a configuration register.
    localparam int KEY_SLOT_REGS = 4;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_A       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_B       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_C       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_D       = 3'd5;

    // Reset values and mask levels.
    localparam logic [SAMPLE_W-1:0] TOL_RESET = 8'd10;
    localparam logic [SAMPLE_W-1:0] MASK_ON   = 8'd255;
    localparam logic [SAMPLE_W-1:0] MASK_OFF  = 8'd0;

    // One key colour, split into its channels.
    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
    } key_t;

    // A pixel travelling down the chain with its running channel hits.
    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic                hit_y;
        logic                hit_cb;
        logic                hit_cr;
    } pix_t;

    // Absolute difference of two samples.
    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[hw/rtl/ytm_cell.sv]
module ytm_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    input  ytm_pkg::pix_t                up_data,
    output logic                         up_ready,
    output logic                         down_valid,
    output ytm_pkg::pix_t                down_data,
    input  logic                         down_ready,
    input  ytm_pkg::key_t                key,
    input  logic                         enable,
    input  logic [ytm_pkg::SAMPLE_W-1:0] tol,
    input  logic [ytm_pkg::SAMPLE_W-1:0] half_tol
);

    logic          valid_reg;
    logic          valid_next;
    ytm_pkg::pix_t data_reg;
    ytm_pkg::pix_t data_next;
    ytm_pkg::pix_t data_calc;

    // The cell takes a beat when it is empty or its own beat moves on.
    assign up_ready = !valid_reg || down_ready;

    // Compare the pixel with this cell's key and fold the hits in.
    always_comb
    begin
        data_calc        = up_data;
        data_calc.hit_y  = up_data.hit_y ||
            (enable && (ytm_pkg::abs_diff(up_data.y, key.y) < tol));
        data_calc.hit_cb = up_data.hit_cb ||
            (enable && (ytm_pkg::abs_diff(up_data.cb, key.cb) < half_tol));
        data_calc.hit_cr = up_data.hit_cr ||
            (enable && (ytm_pkg::abs_diff(up_data.cr, key.cr) < half_tol));
    end

    // Stage load.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            data_next  = data_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

[hw/rtl/yuv_color_tolerance_mask.sv]
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    luma, chroma_blue, chroma_red
// out      source     out_valid / out_stall  mask
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per clock is accepted while in_stall is low; each pixel passes one cell per
// key slot, each cell registering it, before its mask can be taken.
// The rate is set by the chain of compare cells, each a single register stage.
// Reset clears all stages and loads tolerance 10, colour count 0, keys 0.
// A stall on the output holds the last stage; earlier empty stages still fill.
module yuv_color_tolerance_mask #(
    parameter int MAX_COLORS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ytm_pkg::SAMPLE_W-1:0]    luma,
    input  logic [ytm_pkg::SAMPLE_W-1:0]    chroma_blue,
    input  logic [ytm_pkg::SAMPLE_W-1:0]    chroma_red,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ytm_pkg::SAMPLE_W-1:0]    mask,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ytm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ytm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [ytm_pkg::SAMPLE_W-1:0] tol_reg;
    logic [ytm_pkg::SAMPLE_W-1:0] tol_next;
    logic [ytm_pkg::COUNT_W-1:0]  count_reg;
    logic [ytm_pkg::COUNT_W-1:0]  count_next;
    logic [ytm_pkg::KEY_W-1:0]    key_reg  [MAX_COLORS];
    logic [ytm_pkg::KEY_W-1:0]    key_next [MAX_COLORS];
    logic [ytm_pkg::SAMPLE_W-1:0] half_tol;
    logic                         cfg_we;

    logic                         chain_valid [MAX_COLORS+1];
    logic                         chain_ready [MAX_COLORS+1];
    ytm_pkg::pix_t                chain_data  [MAX_COLORS+1];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        tol_next   = tol_reg;
        count_next = count_reg;
        if (cfg_we && (cfg_index == ytm_pkg::REG_TOLERANCE))
        begin
            tol_next = cfg_data[ytm_pkg::SAMPLE_W-1:0];
        end
        if (cfg_we && (cfg_index == ytm_pkg::REG_COLOR_COUNT))
        begin
            count_next = cfg_data[ytm_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= ytm_pkg::TOL_RESET;
            count_reg <= '0;
        end
        else
        begin
            tol_reg   <= tol_next;
            count_reg <= count_next;
        end
    end

    assign half_tol = tol_reg >> 1;

    // Key slots; those without a register keep the colour zero.
    for (genvar i = 0; i < MAX_COLORS; i++)
    begin : g_key
        if (i < ytm_pkg::KEY_SLOT_REGS)
        begin : g_wr
            always_comb
            begin
                key_next[i] = key_reg[i];
                if (cfg_we && (cfg_index ==
                    ytm_pkg::CFG_INDEX_W'(int'(ytm_pkg::REG_KEY_A) + i)))
                begin
                    key_next[i] = cfg_data[ytm_pkg::KEY_W-1:0];
                end
            end
        end
        else
        begin : g_fixed
            assign key_next[i] = '0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                key_reg[i] <= '0;
            end
            else
            begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    // Head of the chain: the pixel enters with no hits.
    assign chain_valid[0]       = in_valid;
    assign chain_data[0].y      = luma;
    assign chain_data[0].cb     = chroma_blue;
    assign chain_data[0].cr     = chroma_red;
    assign chain_data[0].hit_y  = 1'b0;
    assign chain_data[0].hit_cb = 1'b0;
    assign chain_data[0].hit_cr = 1'b0;
    assign in_stall             = !chain_ready[0];

    // One compare cell per key slot.
    for (genvar i = 0; i < MAX_COLORS; i++)
    begin : g_cell
        ytm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[i]),
            .up_data    (chain_data[i]),
            .up_ready   (chain_ready[i]),
            .down_valid (chain_valid[i+1]),
            .down_data  (chain_data[i+1]),
            .down_ready (chain_ready[i+1]),
            .key        (ytm_pkg::key_t'(key_reg[i])),
            .enable     (int'(count_reg) > i),
            .tol        (tol_reg),
            .half_tol   (half_tol)
        );
    end

    // Tail of the chain drives the result port.
    assign chain_ready[MAX_COLORS] = !out_stall;
    assign out_valid = chain_valid[MAX_COLORS];
    assign mask = (chain_data[MAX_COLORS].hit_y && chain_data[MAX_COLORS].hit_cb &&
                   chain_data[MAX_COLORS].hit_cr) ? ytm_pkg::MASK_ON : ytm_pkg::MASK_OFF;

endmodule

[bench/yuv_color_tolerance_mask_test.sv]
`timescale 1ns / 100ps

module yuv_color_tolerance_mask_test;

    localparam int SLOTS       = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    // Register indexes that have no register behind them.
    localparam logic [ytm_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ytm_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ytm_pkg::SAMPLE_W-1:0] y;
        logic [ytm_pkg::SAMPLE_W-1:0] cb;
        logic [ytm_pkg::SAMPLE_W-1:0] cr;
    } pixel_t;

    typedef struct packed {
        pixel_t                       px;
        logic [ytm_pkg::SAMPLE_W-1:0] mask;
    } keyed_pixel_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [ytm_pkg::SAMPLE_W-1:0]    luma = '0;
    logic [ytm_pkg::SAMPLE_W-1:0]    chroma_blue = '0;
    logic [ytm_pkg::SAMPLE_W-1:0]    chroma_red = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [ytm_pkg::SAMPLE_W-1:0]    mask;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ytm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ytm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the register file, starting from the reset values.
    logic [ytm_pkg::SAMPLE_W-1:0]    tol_q = ytm_pkg::TOL_RESET;
    logic [ytm_pkg::COUNT_W-1:0]     count_q = '0;
    logic [ytm_pkg::KEY_W-1:0]       keys_q [SLOTS] = '{default: '0};

    pixel_t                 pending_pixels [$];
    keyed_pixel_t           expected_masks [$];

    logic                   in_taken = 1'b0;
    logic                   long_hold = 1'b0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     cycle_count = 0;
    int                     fail_count = 0;
    int                     pixels_in = 0;
    int                     masks_on = 0;
    int                     masks_off = 0;
    int                     settings_used = 0;
    int                     stall_cycles = 0;
    event                   long_hold_go;

    yuv_color_tolerance_mask #(
        .MAX_COLORS(SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .luma(luma),
        .chroma_blue(chroma_blue),
        .chroma_red(chroma_red),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mask(mask),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Mask expected for one pixel under the current shadow registers.
    // Each channel is ORed over the enabled colours on its own.
    function automatic logic [ytm_pkg::SAMPLE_W-1:0] key_mask_of(input pixel_t px);
        int n;
        int dy;
        int db;
        int dr;
        int half;
        logic hit_y;
        logic hit_cb;
        logic hit_cr;
        n = (count_q > SLOTS) ? SLOTS : int'(count_q);
        half = int'(tol_q) / 2;
        hit_y = 1'b0;
        hit_cb = 1'b0;
        hit_cr = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            dy = int'(px.y) - int'(keys_q[i][23:16]);
            db = int'(px.cb) - int'(keys_q[i][15:8]);
            dr = int'(px.cr) - int'(keys_q[i][7:0]);
            if (dy < 0)
                dy = -dy;
            if (db < 0)
                db = -db;
            if (dr < 0)
                dr = -dr;
            if (dy < int'(tol_q))
                hit_y = 1'b1;
            if (db < half)
                hit_cb = 1'b1;
            if (dr < half)
                hit_cr = 1'b1;
        end
        return (hit_y && hit_cb && hit_cr) ? ytm_pkg::MASK_ON : ytm_pkg::MASK_OFF;
    endfunction

    // A sample close to a key value, sometimes just past the limit.
    function automatic logic [ytm_pkg::SAMPLE_W-1:0] near_sample(
        input logic [ytm_pkg::SAMPLE_W-1:0] k,
        input int lim
    );
        int d;
        int v;
        d = $urandom_range(lim + 1, 0);
        v = ($urandom_range(1, 0) == 1) ? int'(k) + d : int'(k) - d;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[ytm_pkg::SAMPLE_W-1:0];
    endfunction

    // Driver: a new beat is offered once the previous one has been taken.
    always @(negedge clk)
    begin : drive_pixels
        pixel_t px;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                px = pending_pixels.pop_front();
                in_valid <= 1'b1;
                luma <= px.y;
                chroma_blue <= px.cb;
                chroma_red <= px.cr;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, forced high for the whole of a long hold.
    always @(negedge clk)
    begin
        if (long_hold)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Long hold on the output, counted here so the sender keeps offering beats.
    always
    begin
        @(long_hold_go);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
    end

    // Monitor: tracks register writes, predicts each taken pixel and checks each mask beat.
    always @(posedge clk)
    begin : check_beats
        keyed_pixel_t want;
        pixel_t       px;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ytm_pkg::REG_TOLERANCE)
                    tol_q = cfg_data[ytm_pkg::SAMPLE_W-1:0];
                else if (cfg_index == ytm_pkg::REG_COLOR_COUNT)
                    count_q = cfg_data[ytm_pkg::COUNT_W-1:0];
                else if (cfg_index >= ytm_pkg::REG_KEY_A &&
                         cfg_index < ytm_pkg::REG_KEY_A + ytm_pkg::KEY_SLOT_REGS)
                    keys_q[cfg_index - ytm_pkg::REG_KEY_A] = cfg_data;
            end

            if (out_valid && !out_stall)
            begin
                if (mask == ytm_pkg::MASK_ON)
                    masks_on++;
                else
                    masks_off++;
                if (expected_masks.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no mask beat, got mask %0d", $time, mask);
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (mask !== want.mask)
                    begin
                        fail_count++;
                        $display("%0t: mask for pixel (%0d,%0d,%0d): expected %0d, got %0d",
                                 $time, want.px.y, want.px.cb, want.px.cr, want.mask, mask);
                    end
                end
            end

            if (in_valid && in_stall)
                stall_cycles++;

            if (in_valid && !in_stall)
            begin
                px = '{y: luma, cb: chroma_blue, cr: chroma_red};
                want.px = px;
                want.mask = key_mask_of(px);
                expected_masks = {expected_masks, want};
                pixels_in++;
            end
            in_taken <= in_valid && !in_stall;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles, %0d masks still expected",
                     $time, cycle_count, expected_masks.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One register write beat.
    task automatic write_reg(input logic [ytm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ytm_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until no pixel is pending or in flight, then let the chain drain.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_masks.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
    endtask

    task automatic add_pixel(input int y, input int cb, input int cr);
        pixel_t px;
        px = '{y: y[7:0], cb: cb[7:0], cr: cr[7:0]};
        pending_pixels = {pending_pixels, px};
    endtask

    // A fresh random setting of every register, extremes included now and then.
    task automatic random_settings();
        logic [ytm_pkg::SAMPLE_W-1:0] tol;
        logic [ytm_pkg::CFG_DATA_W-1:0] key;
        int pick;
        pick = $urandom_range(9, 0);
        case (pick)
            0: tol = 8'd0;
            1: tol = 8'd1;
            2: tol = 8'd255;
            3: tol = 8'd2;
            default: tol = 8'($urandom_range(60, 3));
        endcase
        write_reg(ytm_pkg::REG_TOLERANCE, {16'h0000, tol});
        if ($urandom_range(9, 0) < 7)
            write_reg(ytm_pkg::REG_COLOR_COUNT, 24'($urandom_range(4, 1)));
        else
            write_reg(ytm_pkg::REG_COLOR_COUNT, 24'($urandom_range(7, 0)));
        for (int i = 0; i < ytm_pkg::KEY_SLOT_REGS; i++)
        begin
            pick = $urandom_range(9, 0);
            key = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
            write_reg(ytm_pkg::CFG_INDEX_W'(int'(ytm_pkg::REG_KEY_A) + i), key);
        end
        if ($urandom_range(3, 0) == 0)
            write_reg($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO, 24'($urandom));
        settings_used++;
    endtask

    // Mostly pixels near the key colours, channels drawn from the same or another slot.
    task automatic queue_random_pixels(input int n);
        int slot_y;
        int slot_c;
        int top;
        int half;
        pixel_t px;
        top = (count_q == 0) ? 0 : ((count_q > SLOTS) ? SLOTS - 1 : int'(count_q) - 1);
        half = int'(tol_q) / 2;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                px = 24'($urandom);
            end
            else
            begin
                slot_y = $urandom_range(top, 0);
                slot_c = ($urandom_range(2, 0) == 0) ? $urandom_range(top, 0) : slot_y;
                px.y = near_sample(keys_q[slot_y][23:16], int'(tol_q));
                px.cb = near_sample(keys_q[slot_c][15:8], half);
                px.cr = near_sample(keys_q[($urandom_range(3, 0) == 0) ? slot_y : slot_c][7:0],
                                    half);
            end
            pending_pixels = {pending_pixels, px};
        end
    endtask

    task automatic run_phase(input int n, input int send_pct, input int stall_pct);
        wait_idle();
        random_settings();
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        queue_random_pixels(n);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting: no colours enabled, so every mask is clear.
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);

        // One colour, pixels either side of each channel limit.
        wait_idle();
        write_reg(ytm_pkg::REG_TOLERANCE, 24'd10);
        write_reg(ytm_pkg::REG_COLOR_COUNT, 24'd1);
        write_reg(ytm_pkg::REG_KEY_A, 24'h6432C8);
        add_pixel(100, 50, 200);
        add_pixel(109, 50, 200);
        add_pixel(110, 50, 200);
        add_pixel(91, 50, 200);
        add_pixel(90, 50, 200);
        add_pixel(100, 54, 200);
        add_pixel(100, 55, 200);
        add_pixel(100, 50, 196);
        add_pixel(100, 50, 195);

        // Channels satisfied by different colours still set the mask.
        wait_idle();
        write_reg(ytm_pkg::REG_COLOR_COUNT, 24'd2);
        write_reg(ytm_pkg::REG_KEY_A, 24'h141414);
        write_reg(ytm_pkg::REG_KEY_B, 24'hC8C8C8);
        add_pixel(20, 200, 20);
        add_pixel(200, 20, 200);

        // Zero tolerance, then a tolerance whose chroma half is zero.
        wait_idle();
        write_reg(ytm_pkg::REG_TOLERANCE, 24'd0);
        add_pixel(20, 20, 20);
        wait_idle();
        write_reg(ytm_pkg::REG_TOLERANCE, 24'd1);
        add_pixel(20, 20, 20);

        // Widest tolerance and a count above the slot limit.
        wait_idle();
        write_reg(ytm_pkg::REG_TOLERANCE, 24'd255);
        write_reg(ytm_pkg::REG_COLOR_COUNT, 24'd7);
        write_reg(ytm_pkg::REG_KEY_C, 24'hFFFFFF);
        write_reg(ytm_pkg::REG_KEY_D, 24'h00FF00);
        add_pixel(0, 255, 0);
        add_pixel(255, 0, 255);
        add_pixel(128, 128, 128);

        // Writes to unused indexes must leave the registers alone.
        wait_idle();
        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'h000000);
        write_reg(ytm_pkg::REG_TOLERANCE, 24'd2);
        write_reg(ytm_pkg::REG_COLOR_COUNT, 24'd4);
        add_pixel(255, 255, 255);
        settings_used = 7;

        // Random part over the idling patterns.
        for (int rep = 0; rep < 2; rep++)
        begin
            run_phase(200, 0, 0);
            run_phase(200, 77, 0);
            run_phase(200, 0, 77);
            run_phase(200, 12, 12);
        end

        // Output held off for a long stretch while beats keep arriving.
        run_phase(150, 0, 0);
        -> long_hold_go;

        wait_idle();
        if (expected_masks.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d masks never arrived", $time, expected_masks.size());
        end
        $display("Checked %0d pixels over %0d register settings: %0d masks set, %0d clear.",
                 pixels_in, settings_used, masks_on, masks_off);
        $display("Input was held back for %0d cycles; %0d mismatches.", stall_cycles, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ytm_pkg.sv
hw/rtl/ytm_cell.sv
hw/rtl/yuv_color_tolerance_mask.sv
bench/yuv_color_tolerance_mask_test.sv
